@@ sv/affine_gap_global_aligner_unit_assert.svh @@
// Assertion macros for the affine gap global aligner.
// Used by affine_gap_global_aligner_unit.sv; expects clk and rst in scope.
`ifndef AFFINE_GAP_GLOBAL_ALIGNER_UNIT_ASSERT_SVH
`define AFFINE_GAP_GLOBAL_ALIGNER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AGA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AGA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/aga_pkg.sv @@
// Shared constants and types of the affine gap global aligner.
// No dependencies; imported by affine_gap_global_aligner_unit.
package aga_pkg;

  localparam logic [7:0] GAP_SYMBOL = 8'd45;
  localparam int FRAC_BITS = 16;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_MATCH_AWARD   = 2'd0,
    REG_MISMATCH      = 2'd1,
    REG_GAP_OPEN      = 2'd2,
    REG_GAP_EXTEND    = 2'd3
  } cfg_reg_t;

  localparam logic [3:0]        MATCH_AWARD_RST = 4'd5;
  localparam logic signed [4:0] MISMATCH_RST    = -5'sd4;
  localparam logic signed [5:0] GAP_OPEN_RST    = -6'sd10;
  localparam logic signed [4:0] GAP_EXTEND_RST  = -5'sd1;

  // Matrix codes: match, gap in first sequence, gap in second sequence.
  typedef logic [1:0] mat_t;
  localparam mat_t MAT_M = 2'd1;
  localparam mat_t MAT_X = 2'd2;
  localparam mat_t MAT_Y = 2'd3;

endpackage

@@ sv/affine_gap_global_aligner_unit.sv @@
// Global aligner with affine gaps: loading, score fill, traceback, column output.
// Depends on aga_pkg and affine_gap_global_aligner_unit_assert.svh.
//
// Each start transfer loads one symbol; the first sequence is loaded, then the
// second, each closed by end_of_sequence, and symbols beyond MAX_LEN are dropped.
// The transfer closing the second sequence raises busy for the alignment of
// lengths n and m: seeding of the score row, the fill (one cell per cycle through
// the row score memory, read ahead with forwarding), picking the end matrix, the
// traceback through the direction memory with its leftover gaps, the emitted
// columns, then a restoring divide for the mismatch fraction. Columns come out in
// forward order as one-cycle result_valid strobes and cannot be held off; the
// last one carries last_column, final_score and mismatch_fraction and is shown
// in the same cycle as busy falls. cfg_ready is always high; write registers
// only while the block is idle.
`include "affine_gap_global_aligner_unit_assert.svh"

module affine_gap_global_aligner_unit
  import aga_pkg::*;
#(
  parameter int MAX_LEN    = 32,
  parameter int SCORE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         symbol,
  input  logic               end_of_sequence,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [5:0]         cfg_data,
  output logic               result_valid,
  output logic [7:0]         first_symbol,
  output logic               first_gap,
  output logic [7:0]         second_symbol,
  output logic               second_gap,
  output logic               last_column,
  output logic signed [12:0] final_score,
  output logic [16:0]        mismatch_fraction
);

  localparam int S  = SCORE_BITS;
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int SA = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int DA = (MAX_LEN > 1) ? $clog2(MAX_LEN * MAX_LEN) : 1;
  localparam int PD = 2 * MAX_LEN;
  localparam int PA = $clog2(PD);
  localparam int PC = $clog2(PD + 1);
  localparam int DW = PC + FRAC_BITS;
  localparam int DC = $clog2(DW);
  localparam int XW = ((S + 2) > (LW + 6)) ? (S + 2) : (LW + 6);
  localparam longint SMAX_L = (longint'(1) <<< (S - 1)) - 1;
  localparam longint SMIN_L = -SMAX_L - 1;
  localparam logic signed [S-1:0]  SMAX   = S'(SMAX_L);
  localparam logic signed [S-1:0]  SMIN   = S'(SMIN_L);
  localparam logic signed [XW-1:0] SMAX_X = XW'(SMAX_L);
  localparam logic signed [XW-1:0] SMIN_X = XW'(SMIN_L);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_FILL, S_PICK, S_TB_RD, S_TB_USE, S_TB_REST,
    S_EM_RD, S_EM_ST, S_EM_OUT, S_DIV
  } state_t;

  function automatic logic signed [S-1:0] sat(input logic signed [XW-1:0] v);
    logic signed [S-1:0] r;
    if (v > SMAX_X) r = SMAX;
    else if (v < SMIN_X) r = SMIN;
    else r = v[S-1:0];
    return r;
  endfunction

  // Memories.
  logic [7:0]     first_mem  [MAX_LEN];
  logic [7:0]     second_mem [MAX_LEN];
  logic [3*S-1:0] row_mem    [MAX_LEN+1];
  logic [3:0]     dir_mem    [MAX_LEN*MAX_LEN];
  logic [1:0]     path_mem   [PD];

  logic [7:0]     first_q, second_q;
  logic [3*S-1:0] row_q;
  logic [3:0]     dir_q;
  logic [1:0]     path_q;

  // Control and datapath registers.
  state_t            state;
  logic [LW-1:0]     n_len, m_len;
  logic              loading2;
  logic [3:0]        ma;
  logic signed [4:0] mm;
  logic signed [5:0] go;
  logic signed [4:0] ge;

  logic signed [XW-1:0] acc;
  logic [LW-1:0]     ri, rj, ci, cj;
  logic              issue_on, c_on, fwd;
  logic [3*S-1:0]    fwd_data;
  logic signed [S-1:0] dm, dx, dy, lm, lx, ly;
  logic [DA-1:0]     dwa;

  logic signed [S-1:0] fs;
  mat_t              mat;
  logic [LW-1:0]     ti, tj;
  logic [DA-1:0]     taddr;
  logic [PC-1:0]     cnt;

  logic [PC-1:0]     ek;
  logic [LW-1:0]     ii, jj;
  mat_t              code_r;
  logic [PC-1:0]     miss;

  logic [PC-1:0]     rem;
  logic [DW-1:0]     dvd;
  logic [16:0]       quo;
  logic [DC-1:0]     dc;

  // Combinational signals.
  logic              accept;
  logic              fw_we, sw_we;
  logic [LW-1:0]     ri_m1, rj_m1;
  logic [SA-1:0]     first_ra, second_ra;
  logic              row_we;
  logic [LW-1:0]     row_wa;
  logic [3*S-1:0]    row_wd;
  logic              path_we;
  mat_t              path_wd;

  logic signed [XW-1:0] ge_x, go_x, addx;
  logic [3*S-1:0]    u_word;
  logic signed [S-1:0] u_m, u_x, u_y, d_m, d_x, d_y, l_m, l_x, l_y;
  logic signed [S-1:0] smm, smx, smy, sxm, sxx, sym, syy;
  logic signed [S-1:0] new_m, new_x, new_y, bprev, bcur;
  logic [3:0]        new_dir;

  mat_t              pick_mat;
  logic signed [S-1:0] pick_fs;
  mat_t              step_mat;

  logic [7:0]        col_a, col_b;
  logic              col_ga, col_gb, col_miss;
  logic [PC-1:0]     miss_next;

  logic [PC:0]       div_t, div_sub;
  logic              div_ge;
  logic signed [31:0] fs32;
  logic signed [12:0] fs_clip;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign fw_we = accept && !loading2 && (n_len < LW'(MAX_LEN));
  assign sw_we = accept && loading2 && (m_len < LW'(MAX_LEN));

  assign ri_m1 = ri - 1'b1;
  assign rj_m1 = rj - 1'b1;
  assign first_ra  = (state == S_FILL) ? ri_m1[SA-1:0] : ii[SA-1:0];
  assign second_ra = (state == S_FILL) ? rj_m1[SA-1:0] : jj[SA-1:0];

  // Cell computation.
  assign ge_x   = XW'(ge);
  assign go_x   = XW'(go);
  assign addx   = (first_q == second_q) ? XW'(signed'({1'b0, ma})) : XW'(mm);
  assign u_word = fwd ? fwd_data : row_q;
  assign u_m    = u_word[3*S-1:2*S];
  assign u_x    = u_word[2*S-1:S];
  assign u_y    = u_word[S-1:0];
  assign bcur   = sat(acc);
  assign bprev  = sat(acc - ge_x);

  always_comb begin
    // The left border of a row and its upper neighbor come from the gap formula.
    if (cj == LW'(1)) begin
      if (ci == LW'(1)) begin
        d_m = '0;
        d_x = '0;
        d_y = '0;
      end else begin
        d_m = SMIN;
        d_x = SMIN;
        d_y = bprev;
      end
      l_m = SMIN;
      l_x = SMIN;
      l_y = bcur;
    end else begin
      d_m = dm;
      d_x = dx;
      d_y = dy;
      l_m = lm;
      l_x = lx;
      l_y = ly;
    end
    smm = sat(XW'(d_m) + addx);
    smx = sat(XW'(d_x) + addx);
    smy = sat(XW'(d_y) + addx);
    sxm = sat(XW'(l_m) + go_x + ge_x);
    sxx = sat(XW'(l_x) + ge_x);
    sym = sat(XW'(u_m) + go_x + ge_x);
    syy = sat(XW'(u_y) + ge_x);
    if (smm >= smx && smm >= smy) begin
      new_m = smm;
      new_dir[1:0] = MAT_M;
    end else if (smx >= smy) begin
      new_m = smx;
      new_dir[1:0] = MAT_X;
    end else begin
      new_m = smy;
      new_dir[1:0] = MAT_Y;
    end
    if (sxm >= sxx) begin
      new_x = sxm;
      new_dir[2] = 1'b0;
    end else begin
      new_x = sxx;
      new_dir[2] = 1'b1;
    end
    if (sym >= syy) begin
      new_y = sym;
      new_dir[3] = 1'b0;
    end else begin
      new_y = syy;
      new_dir[3] = 1'b1;
    end
  end

  always_comb begin
    row_we = 1'b0;
    row_wa = cj;
    row_wd = {new_m, new_x, new_y};
    if (state == S_INIT) begin
      row_we = 1'b1;
      row_wa = rj;
      row_wd = {SMIN, bcur, SMIN};
    end else if (state == S_FILL && c_on) begin
      row_we = 1'b1;
    end
  end

  // End matrix choice favors the gap matrices.
  always_comb begin
    if (lx >= lm && lx >= ly) begin
      pick_mat = MAT_X;
      pick_fs  = lx;
    end else if (ly >= lm && ly >= lx) begin
      pick_mat = MAT_Y;
      pick_fs  = ly;
    end else begin
      pick_mat = MAT_M;
      pick_fs  = lm;
    end
  end

  always_comb begin
    case (mat)
      MAT_M:   step_mat = (dir_q[1:0] == 2'd0) ? MAT_M : dir_q[1:0];
      MAT_X:   step_mat = dir_q[2] ? MAT_X : MAT_M;
      default: step_mat = dir_q[3] ? MAT_Y : MAT_M;
    endcase
  end

  assign path_we = (state == S_TB_USE) ||
                   (state == S_TB_REST && (ti != '0 || tj != '0));
  assign path_wd = (state == S_TB_USE) ? mat : ((ti != '0) ? MAT_Y : MAT_X);

  // Output column.
  assign col_ga    = (code_r == MAT_X);
  assign col_gb    = (code_r == MAT_Y);
  assign col_a     = col_ga ? GAP_SYMBOL : first_q;
  assign col_b     = col_gb ? GAP_SYMBOL : second_q;
  assign col_miss  = col_ga || col_gb || (col_a != col_b);
  assign miss_next = miss + PC'(col_miss);

  // Restoring divide step.
  assign div_t   = {rem, dvd[DW-1]};
  assign div_sub = div_t - {1'b0, cnt};
  assign div_ge  = (div_t >= {1'b0, cnt});

  assign fs32 = 32'(fs);
  always_comb begin
    if (fs32 > 32'sd4095) fs_clip = 13'sd4095;
    else if (fs32 < -32'sd4096) fs_clip = -13'sd4096;
    else fs_clip = fs32[12:0];
  end

  // Memory ports.
  always_ff @(posedge clk) begin
    if (fw_we) first_mem[n_len[SA-1:0]] <= symbol;
    first_q <= first_mem[first_ra];
  end

  always_ff @(posedge clk) begin
    if (sw_we) second_mem[m_len[SA-1:0]] <= symbol;
    second_q <= second_mem[second_ra];
  end

  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_wa] <= row_wd;
    row_q <= row_mem[rj];
  end

  always_ff @(posedge clk) begin
    if (state == S_FILL && c_on) dir_mem[dwa] <= new_dir;
    dir_q <= dir_mem[taddr];
  end

  always_ff @(posedge clk) begin
    if (path_we) path_mem[cnt[PA-1:0]] <= path_wd;
    path_q <= path_mem[ek[PA-1:0]];
  end

  // Main sequencer with registered result outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      n_len        <= '0;
      m_len        <= '0;
      loading2     <= 1'b0;
      ma           <= MATCH_AWARD_RST;
      mm           <= MISMATCH_RST;
      go           <= GAP_OPEN_RST;
      ge           <= GAP_EXTEND_RST;
      issue_on     <= 1'b0;
      c_on         <= 1'b0;
      fwd          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      fwd          <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_MATCH_AWARD: ma <= cfg_data[3:0];
          REG_MISMATCH:    mm <= cfg_data[4:0];
          REG_GAP_OPEN:    go <= cfg_data[5:0];
          REG_GAP_EXTEND:  ge <= cfg_data[4:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (!loading2) begin
              if (fw_we) n_len <= n_len + 1'b1;
              if (end_of_sequence) loading2 <= 1'b1;
            end else begin
              if (sw_we) m_len <= m_len + 1'b1;
              if (end_of_sequence) begin
                state <= S_INIT;
                rj    <= LW'(1);
                acc   <= go_x + ge_x;
              end
            end
          end
        end
        S_INIT: begin
          // Seed the top score row, one entry per cycle.
          acc <= acc + ge_x;
          if (rj == m_len) begin
            state    <= S_FILL;
            acc      <= go_x + ge_x;
            ri       <= LW'(1);
            rj       <= LW'(1);
            issue_on <= 1'b1;
            c_on     <= 1'b0;
            dwa      <= '0;
          end else begin
            rj <= rj + 1'b1;
          end
        end
        S_FILL: begin
          c_on <= issue_on;
          ci   <= ri;
          cj   <= rj;
          if (issue_on) begin
            // A read that hits the entry written this cycle takes the new data.
            fwd      <= c_on && (rj == cj);
            fwd_data <= {new_m, new_x, new_y};
            if (rj == m_len) begin
              rj <= LW'(1);
              if (ri == n_len) issue_on <= 1'b0;
              else ri <= ri + 1'b1;
            end else begin
              rj <= rj + 1'b1;
            end
          end
          if (c_on) begin
            dm  <= u_m;
            dx  <= u_x;
            dy  <= u_y;
            lm  <= new_m;
            lx  <= new_x;
            ly  <= new_y;
            dwa <= dwa + 1'b1;
            if (cj == m_len) begin
              acc <= acc + ge_x;
              if (ci == n_len) begin
                state <= S_PICK;
                c_on  <= 1'b0;
              end
            end
          end
        end
        S_PICK: begin
          mat   <= pick_mat;
          fs    <= pick_fs;
          ti    <= n_len;
          tj    <= m_len;
          taddr <= dwa - 1'b1;
          cnt   <= '0;
          state <= S_TB_RD;
        end
        S_TB_RD: begin
          if (ti != '0 && tj != '0) state <= S_TB_USE;
          else state <= S_TB_REST;
        end
        S_TB_USE: begin
          cnt <= cnt + 1'b1;
          mat <= step_mat;
          case (mat)
            MAT_M: begin
              ti    <= ti - 1'b1;
              tj    <= tj - 1'b1;
              taddr <= taddr - DA'(m_len) - 1'b1;
            end
            MAT_X: begin
              tj    <= tj - 1'b1;
              taddr <= taddr - 1'b1;
            end
            default: begin
              ti    <= ti - 1'b1;
              taddr <= taddr - DA'(m_len);
            end
          endcase
          state <= S_TB_RD;
        end
        S_TB_REST: begin
          // Leftover symbols become gap columns at the start of the alignment.
          if (ti != '0) begin
            ti  <= ti - 1'b1;
            cnt <= cnt + 1'b1;
          end else if (tj != '0) begin
            tj  <= tj - 1'b1;
            cnt <= cnt + 1'b1;
          end else begin
            ek    <= cnt - 1'b1;
            ii    <= '0;
            jj    <= '0;
            miss  <= '0;
            state <= S_EM_RD;
          end
        end
        S_EM_RD: begin
          state <= S_EM_ST;
        end
        S_EM_ST: begin
          code_r <= path_q;
          if (path_q != MAT_X) ii <= ii + 1'b1;
          if (path_q != MAT_Y) jj <= jj + 1'b1;
          state <= S_EM_OUT;
        end
        S_EM_OUT: begin
          first_symbol      <= col_a;
          first_gap         <= col_ga;
          second_symbol     <= col_b;
          second_gap        <= col_gb;
          last_column       <= 1'b0;
          final_score       <= '0;
          mismatch_fraction <= '0;
          miss              <= miss_next;
          if (ek == '0) begin
            dvd   <= {miss_next, {FRAC_BITS{1'b0}}};
            rem   <= '0;
            dc    <= '0;
            state <= S_DIV;
          end else begin
            result_valid <= 1'b1;
            ek           <= ek - 1'b1;
            state        <= S_EM_RD;
          end
        end
        S_DIV: begin
          rem <= div_ge ? div_sub[PC-1:0] : div_t[PC-1:0];
          quo <= {quo[15:0], div_ge};
          dvd <= {dvd[DW-2:0], 1'b0};
          dc  <= dc + 1'b1;
          if (dc == DC'(DW - 1)) begin
            result_valid      <= 1'b1;
            last_column       <= 1'b1;
            final_score       <= fs_clip;
            mismatch_fraction <= {quo[15:0], div_ge};
            n_len             <= '0;
            m_len             <= '0;
            loading2          <= 1'b0;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `AGA_ASSERT_NOW(a_gap_pair, result_valid, !(first_gap && second_gap), "column has gaps on both sides")
  `AGA_ASSERT_NOW(a_frac_range, result_valid && last_column, mismatch_fraction <= 17'd65536, "mismatch fraction above one")
  `AGA_ASSERT_NOW(a_plain_zero, result_valid && !last_column, final_score == 13'sd0 && mismatch_fraction == 17'd0, "inner column carries score")
  `AGA_ASSERT_NEXT(a_align_start, start && !busy && loading2 && end_of_sequence, busy, "alignment did not start")
  `AGA_ASSERT_NOW(a_fill_index, c_on, cj != '0 && cj <= m_len && ci != '0 && ci <= n_len, "fill cell out of range")
  `AGA_ASSERT_NOW(a_path_bound, state == S_TB_USE, cnt < PC'(PD), "traceback path overflow")

endmodule

@@ tb/testbench.sv @@
// Self-checking bench for affine_gap_global_aligner_unit: loads sequence pairs and
// checks every aligned column against a built-in Gotoh alignment predictor.
// Depends on aga_pkg and the aligner RTL only.
module testbench;
  import aga_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN = 32;
  localparam int SCORE_HI = 32767;
  localparam int SCORE_LO = -32768;

  typedef struct {
    logic [7:0]         fsym;
    logic               fgap;
    logic [7:0]         ssym;
    logic               sgap;
    logic               last;
    logic signed [12:0] score;
    logic [16:0]        frac;
  } column_t;

  typedef struct {
    logic [7:0]  sym;
    logic        eos;
    bit          known;
    int          score;
    int          frac;
  } load_row_t;

  logic clk, rst, start, busy, end_of_sequence, cfg_valid, cfg_ready, result_valid;
  logic [7:0] symbol, first_symbol, second_symbol;
  logic [1:0] cfg_index;
  logic [5:0] cfg_data;
  logic first_gap, second_gap, last_column;
  logic signed [12:0] final_score;
  logic [16:0] mismatch_fraction;

  affine_gap_global_aligner_unit dut (
    .clk, .rst, .start, .busy, .symbol, .end_of_sequence,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .result_valid, .first_symbol, .first_gap, .second_symbol, .second_gap,
    .last_column, .final_score, .mismatch_fraction
  );

  // Predictor state.
  logic [3:0]        match_award;
  logic signed [4:0] mismatch_pen;
  logic signed [5:0] gap_open;
  logic signed [4:0] gap_extend;
  logic [7:0] first_seq [MAX_LEN];
  logic [7:0] second_seq [MAX_LEN];
  int first_len, second_len;
  bit loading_second;
  int prev_m [MAX_LEN+1], prev_x [MAX_LEN+1], prev_y [MAX_LEN+1];
  int cur_m [MAX_LEN+1], cur_x [MAX_LEN+1], cur_y [MAX_LEN+1];
  logic [3:0] trace_dir [MAX_LEN+1][MAX_LEN+1];
  mat_t path [2*MAX_LEN];

  column_t expected_columns [$];
  int errors;
  int idle_pct;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("affine_gap_global_aligner_unit regression: fail");
    $finish;
  end

  function automatic int sat(int v);
    if (v > SCORE_HI) return SCORE_HI;
    if (v < SCORE_LO) return SCORE_LO;
    return v;
  endfunction

  // Fills the three matrices, traces back and queues the aligned columns.
  function automatic void predict_alignment();
    int add, smm, smx, smy, sxm, sxx, sym, syy, fs, cnt, miss, ii, jj;
    int ma, mm, go, ge;
    int i, j;
    logic [3:0] d;
    mat_t mat, code;
    column_t c;
    ma = int'(match_award);
    mm = int'(mismatch_pen);
    go = int'(gap_open);
    ge = int'(gap_extend);
    cnt = 0; miss = 0; ii = 0; jj = 0;
    prev_m[0] = 0; prev_x[0] = 0; prev_y[0] = 0;
    for (j = 1; j <= second_len; j++) begin
      prev_m[j] = SCORE_LO;
      prev_x[j] = sat(go + j * ge);
      prev_y[j] = SCORE_LO;
    end
    for (i = 1; i <= first_len; i++) begin
      cur_m[0] = SCORE_LO;
      cur_x[0] = SCORE_LO;
      cur_y[0] = sat(go + i * ge);
      for (j = 1; j <= second_len; j++) begin
        add = (first_seq[i-1] == second_seq[j-1]) ? ma : mm;
        smm = sat(prev_m[j-1] + add);
        smx = sat(prev_x[j-1] + add);
        smy = sat(prev_y[j-1] + add);
        sxm = sat(cur_m[j-1] + go + ge);
        sxx = sat(cur_x[j-1] + ge);
        sym = sat(prev_m[j] + go + ge);
        syy = sat(prev_y[j] + ge);
        if (smm >= smx && smm >= smy) begin
          cur_m[j] = smm; d = 4'd1;
        end else if (smx >= smy) begin
          cur_m[j] = smx; d = 4'd2;
        end else begin
          cur_m[j] = smy; d = 4'd3;
        end
        if (sxm >= sxx) cur_x[j] = sxm;
        else begin
          cur_x[j] = sxx; d[2] = 1'b1;
        end
        if (sym >= syy) cur_y[j] = sym;
        else begin
          cur_y[j] = syy; d[3] = 1'b1;
        end
        trace_dir[i][j] = d;
      end
      for (j = 0; j <= second_len; j++) begin
        prev_m[j] = cur_m[j]; prev_x[j] = cur_x[j]; prev_y[j] = cur_y[j];
      end
    end
    // The end matrix prefers a gap in the first sequence, then in the second.
    j = second_len;
    if (prev_x[j] >= prev_m[j] && prev_x[j] >= prev_y[j]) begin
      mat = MAT_X; fs = prev_x[j];
    end else if (prev_y[j] >= prev_m[j]) begin
      mat = MAT_Y; fs = prev_y[j];
    end else begin
      mat = MAT_M; fs = prev_m[j];
    end
    i = first_len;
    while (i > 0 && j > 0 && cnt < 2*MAX_LEN) begin
      d = trace_dir[i][j];
      path[cnt++] = mat;
      if (mat == MAT_M) begin
        i--; j--; mat = d[1:0];
      end else if (mat == MAT_X) begin
        j--; mat = d[2] ? MAT_X : MAT_M;
      end else begin
        i--; mat = d[3] ? MAT_Y : MAT_M;
      end
      if (mat == 2'd0) mat = MAT_M;
    end
    while (i > 0 && cnt < 2*MAX_LEN) begin
      path[cnt++] = MAT_Y; i--;
    end
    while (j > 0 && cnt < 2*MAX_LEN) begin
      path[cnt++] = MAT_X; j--;
    end
    if (fs > 4095) fs = 4095;
    if (fs < -4096) fs = -4096;
    for (int k = 0; k < cnt; k++) begin
      code = path[cnt-1-k];
      c = '{GAP_SYMBOL, 1'b1, GAP_SYMBOL, 1'b1, 1'b0, '0, '0};
      if (code != MAT_X) begin
        c.fsym = first_seq[ii]; c.fgap = 1'b0; ii++;
      end
      if (code != MAT_Y) begin
        c.ssym = second_seq[jj]; c.sgap = 1'b0; jj++;
      end
      if (c.fgap || c.sgap || c.fsym != c.ssym) miss++;
      if (k == cnt - 1) begin
        c.last = 1'b1;
        c.score = fs[12:0];
        c.frac = 17'((miss * 65536) / cnt);
      end
      expected_columns = {expected_columns, c};
    end
  endfunction

  function automatic void predict_load(logic [7:0] s, logic eos);
    if (!loading_second) begin
      if (first_len < MAX_LEN) first_seq[first_len++] = s;
      if (eos) loading_second = 1;
    end else begin
      if (second_len < MAX_LEN) second_seq[second_len++] = s;
      if (eos) begin
        predict_alignment();
        first_len = 0; second_len = 0; loading_second = 0;
      end
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    column_t c;
    if (!rst && result_valid) begin
      if (expected_columns.size() == 0) report_mismatch("unexpected column", 1, 0);
      else begin
        c = expected_columns.pop_front();
        if (first_symbol != c.fsym) report_mismatch("first_symbol", first_symbol, c.fsym);
        if (first_gap != c.fgap) report_mismatch("first_gap", first_gap, c.fgap);
        if (second_symbol != c.ssym) report_mismatch("second_symbol", second_symbol, c.ssym);
        if (second_gap != c.sgap) report_mismatch("second_gap", second_gap, c.sgap);
        if (last_column != c.last) report_mismatch("last_column", last_column, c.last);
        if (final_score != c.score) report_mismatch("final_score", final_score, c.score);
        if (mismatch_fraction != c.frac)
          report_mismatch("mismatch_fraction", mismatch_fraction, c.frac);
      end
    end
  end

  // One symbol transfer; start stays high across back-to-back transfers.
  task automatic load_symbol(logic [7:0] s, logic eos);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    symbol <= s;
    end_of_sequence <= eos;
    do @(posedge clk); while (busy);
    predict_load(s, eos);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_columns.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Leaves cfg_valid high so that writes can follow back to back.
  task automatic write_reg(cfg_reg_t idx, logic [5:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MATCH_AWARD: match_award = data[3:0];
      REG_MISMATCH:    mismatch_pen = data[4:0];
      REG_GAP_OPEN:    gap_open = data;
      REG_GAP_EXTEND:  gap_extend = data[4:0];
      default: ;
    endcase
  endtask

  function automatic logic [7:0] rand_symbol();
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(0, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic load_sequence(output int len);
    // Now and then a sequence runs past the store, so its tail is dropped.
    len = ($urandom_range(0, 14) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 8);
    for (int k = 0; k < len; k++) load_symbol(rand_symbol(), k == len - 1);
  endtask

  load_row_t directed [] = '{
    '{8'h00, 1'b1, 0, 0, 0}, '{8'h00, 1'b1, 1, 5, 0},
    '{8'hFF, 1'b1, 0, 0, 0}, '{8'h00, 1'b1, 1, -4, 65536},
    '{8'h55, 1'b0, 0, 0, 0}, '{8'hAA, 1'b0, 0, 0, 0}, '{8'h12, 1'b1, 0, 0, 0},
    '{8'h55, 1'b1, 0, 0, 0},
    '{8'h01, 1'b1, 0, 0, 0}, '{8'h01, 1'b0, 0, 0, 0}, '{8'h02, 1'b0, 0, 0, 0},
    '{8'h80, 1'b0, 0, 0, 0}, '{8'h01, 1'b1, 0, 0, 0},
    '{8'h07, 1'b1, 0, 0, 0}, '{8'h07, 1'b1, 1, 5, 0}
  };

  initial begin
    int sent;
    int len_a, len_b;
    errors = 0;
    idle_pct = 6;
    rst = 1'b1; start = 1'b0; symbol = '0; end_of_sequence = 1'b0;
    cfg_valid = 1'b0; cfg_index = REG_MATCH_AWARD; cfg_data = '0;
    match_award = MATCH_AWARD_RST; mismatch_pen = MISMATCH_RST;
    gap_open = GAP_OPEN_RST; gap_extend = GAP_EXTEND_RST;
    first_len = 0; second_len = 0; loading_second = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[r]) begin
      load_symbol(directed[r].sym, directed[r].eos);
      // Known totals replace the predicted ones on the closing column.
      if (directed[r].known) begin
        expected_columns[$].score = 13'(directed[r].score);
        expected_columns[$].frac = 17'(directed[r].frac);
      end
    end
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: begin
          write_reg(REG_MATCH_AWARD, 6'd15); write_reg(REG_MISMATCH, 6'h10);
          write_reg(REG_GAP_OPEN, 6'h20);    write_reg(REG_GAP_EXTEND, 6'h10);
        end
        2: begin
          write_reg(REG_MATCH_AWARD, 6'd0); write_reg(REG_MISMATCH, 6'd0);
          write_reg(REG_GAP_OPEN, 6'd0);    write_reg(REG_GAP_EXTEND, 6'd0);
        end
        3, 4, 5: begin
          write_reg(REG_MATCH_AWARD, 6'($urandom));
          write_reg(REG_MISMATCH, {$urandom_range(0, 1) ? 2'b11 : 2'b10, 4'($urandom)});
          write_reg(REG_GAP_OPEN, {1'b1, 5'($urandom)});
          write_reg(REG_GAP_EXTEND, {$urandom_range(0, 1) ? 2'b11 : 2'b10, 4'($urandom)});
        end
        default: ;
      endcase
      cfg_valid <= 1'b0;
      idle_pct = (phase % 3 == 0) ? 6 : (phase % 3 == 1) ? 49 : 0;
      sent = 0;
      while (sent < 20) begin
        load_sequence(len_a);
        load_sequence(len_b);
        sent += len_a + len_b;
      end
      drain();
    end

    if (errors == 0) $display("affine_gap_global_aligner_unit regression: pass");
    else $display("affine_gap_global_aligner_unit regression: fail");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+sv
sv/aga_pkg.sv
sv/affine_gap_global_aligner_unit.sv
tb/testbench.sv
